// ===== hw/rtl/cpfa_pkg.sv =====
// Shared types, constants and helpers for the contiguous page frame allocator.
// Used by cpfa_frame_table, cpfa_ctrl and the top level; depends on nothing.
package cpfa_pkg;

  // Frame table geometry: 4 KiB frames
  localparam int FRAME_COUNT = 1024;
  localparam int FRAME_W     = $clog2(FRAME_COUNT);
  localparam int FRAME_SHIFT = 12;
  localparam int PAGE_ROUND  = (1 << FRAME_SHIFT) - 1;

  // Request and result field widths
  localparam int LEN_W   = 24;
  localparam int ADDR_W  = 24;
  localparam int OWNER_W = 8;
  localparam int BASE_W  = 22;

  // Derived widths: rounded length, raw page count, frame number of an address
  localparam int ROUND_W   = LEN_W + 1;
  localparam int NEEDRAW_W = ROUND_W - FRAME_SHIFT;
  localparam int PF_W      = ADDR_W - FRAME_SHIFT;
  // Counters that must hold FRAME_COUNT itself
  localparam int CNT_W     = FRAME_W + 1;

  // Request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SEARCH,
    S_MARK,
    S_FREE
  } state_t;

  // One frame table entry
  typedef struct packed {
    logic               in_use;
    logic [OWNER_W-1:0] owner;
    logic [FRAME_W-1:0] run_start;
  } frame_word_t;

  // Access request from the controller to the frame table
  typedef struct packed {
    logic               rd_en;
    logic [FRAME_W-1:0] rd_addr;
    logic               wr_en;
    logic [FRAME_W-1:0] wr_addr;
    frame_word_t        wr_data;
  } mem_req_t;

  // Byte address of a frame, kept to the result width
  function automatic logic [BASE_W-1:0] frame_to_base(input logic [FRAME_W-1:0] frame);
    logic [31:0] byte_addr;
    byte_addr = 32'(frame) << FRAME_SHIFT;
    return byte_addr[BASE_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/contiguous_page_frame_allocator_unit.sv =====
// Top level of the first-fit contiguous page frame allocator.
// Depends on cpfa_pkg, cpfa_frame_table and cpfa_ctrl.
//
//   channel   transfer when      payload
//   -------   ----------------   -------------------------------------------------
//   request   start && !busy     opcode, length_bytes, free_address, requester_id
//   result    done (one cycle)   status, base_address
//
// After reset the unit holds busy while it clears the table.
// Allocate: take the request, scan the table (one table read per cycle on the single
// read port), then write one entry per page claimed.
// Free: take the request, then read and release the frames of the run in order, stopping
// at the last frame or at a frame of another run; nothing is released on an error.
// Oversized requests and addresses beyond the table answer the cycle after the transfer.
// The result strobe lasts one cycle; the receiver cannot stall it.
module contiguous_page_frame_allocator_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         opcode,
  input  logic [cpfa_pkg::LEN_W-1:0]   length_bytes,
  input  logic [cpfa_pkg::ADDR_W-1:0]  free_address,
  input  logic [cpfa_pkg::OWNER_W-1:0] requester_id,
  output logic                         done,
  output logic                         status,
  output logic [cpfa_pkg::BASE_W-1:0]  base_address
);
  import cpfa_pkg::*;

  mem_req_t    mem_req;
  frame_word_t rd_data;

  // Sequencer
  cpfa_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .length_bytes (length_bytes),
    .free_address (free_address),
    .requester_id (requester_id),
    .done         (done),
    .status       (status),
    .base_address (base_address),
    .mem_req      (mem_req),
    .rd_data      (rd_data)
  );

  // Frame table
  cpfa_frame_table u_table (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

endmodule

// ===== hw/rtl/cpfa_frame_table.sv =====
// Frame table storage: one synchronous memory holding use flag, owner and run start.
// Depends on cpfa_pkg for the entry and request types.
module cpfa_frame_table (
  input  logic                  clk,
  input  cpfa_pkg::mem_req_t    mem_req,
  output cpfa_pkg::frame_word_t rd_data
);
  import cpfa_pkg::*;

  frame_word_t mem [FRAME_COUNT];

  // Write port
  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[mem_req.wr_addr] <= mem_req.wr_data;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (mem_req.rd_en) begin
      rd_data <= mem[mem_req.rd_addr];
    end
  end

endmodule

// ===== hw/rtl/cpfa_ctrl.sv =====
// Request sequencer: table clear after reset, first-fit scan, run marking and release walk.
// Depends on cpfa_pkg; drives the frame table through a mem_req_t request.
module cpfa_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         opcode,
  input  logic [cpfa_pkg::LEN_W-1:0]   length_bytes,
  input  logic [cpfa_pkg::ADDR_W-1:0]  free_address,
  input  logic [cpfa_pkg::OWNER_W-1:0] requester_id,
  output logic                         done,
  output logic                         status,
  output logic [cpfa_pkg::BASE_W-1:0]  base_address,
  output cpfa_pkg::mem_req_t           mem_req,
  input  cpfa_pkg::frame_word_t        rd_data
);
  import cpfa_pkg::*;

  localparam logic [FRAME_W-1:0] LAST_FRAME = FRAME_W'(FRAME_COUNT - 1);

  state_t             state, state_next;
  logic [CNT_W-1:0]   scan, scan_next;
  logic               rd_pend, rd_pend_next;
  logic [FRAME_W-1:0] rd_idx, rd_idx_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [CNT_W-1:0]   need, need_next;
  logic [FRAME_W-1:0] run_first, run_first_next;
  logic [FRAME_W-1:0] mark_addr, mark_addr_next;
  logic [OWNER_W-1:0] who, who_next;
  logic [FRAME_W-1:0] pf, pf_next;
  logic               first, first_next;
  logic               done_next;
  logic               status_next;
  logic [BASE_W-1:0]  base_next;

  logic [ROUND_W-1:0]   rounded;
  logic [NEEDRAW_W-1:0] need_raw;
  logic                 too_long;
  logic [PF_W-1:0]      pf_in;
  logic                 pf_too_far;
  logic [CNT_W-1:0]     count_plus;
  logic                 stay;
  logic [FRAME_W-1:0]   found_first;

  // Round the byte length up to pages and split out the frame of the free address
  assign rounded    = {1'b0, length_bytes} + ROUND_W'(PAGE_ROUND);
  assign need_raw   = rounded[ROUND_W-1:FRAME_SHIFT];
  assign too_long   = 32'(need_raw) > FRAME_COUNT;
  assign pf_in      = free_address[ADDR_W-1:FRAME_SHIFT];
  assign pf_too_far = 32'(pf_in) >= FRAME_COUNT;
  assign count_plus = count + CNT_W'(1);
  assign found_first = (count == '0) ? rd_idx : run_first;

  assign busy = (state != S_IDLE);

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      scan    <= '0;
      rd_pend <= 1'b0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      scan    <= scan_next;
      rd_pend <= rd_pend_next;
      done    <= done_next;
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    rd_idx       <= rd_idx_next;
    count        <= count_next;
    need         <= need_next;
    run_first    <= run_first_next;
    mark_addr    <= mark_addr_next;
    who          <= who_next;
    pf           <= pf_next;
    first        <= first_next;
    status       <= status_next;
    base_address <= base_next;
  end

  // Next state, table accesses and result
  always_comb begin
    state_next     = state;
    scan_next      = scan;
    rd_pend_next   = 1'b0;
    rd_idx_next    = rd_idx;
    count_next     = count;
    need_next      = need;
    run_first_next = run_first;
    mark_addr_next = mark_addr;
    who_next       = who;
    pf_next        = pf;
    first_next     = first;
    done_next      = 1'b0;
    status_next    = status;
    base_next      = base_address;
    mem_req        = '0;
    stay           = 1'b0;

    case (state)
      // Sweep zeros through the table after reset
      S_CLEAR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = scan[FRAME_W-1:0];
        mem_req.wr_data = '0;
        scan_next       = scan + CNT_W'(1);
        if (scan[FRAME_W-1:0] == LAST_FRAME) begin
          scan_next  = '0;
          state_next = S_IDLE;
        end
      end

      // Take a request; reject out-of-range ones at once
      S_IDLE: begin
        if (start) begin
          who_next   = requester_id;
          scan_next  = '0;
          count_next = '0;
          first_next = 1'b1;
          if (opcode == OP_FREE) begin
            if (pf_too_far) begin
              done_next   = 1'b1;
              status_next = STATUS_ERR;
              base_next   = '0;
            end else begin
              pf_next    = pf_in[FRAME_W-1:0];
              scan_next  = {1'b0, pf_in[FRAME_W-1:0]};
              state_next = S_FREE;
            end
          end else begin
            if (too_long) begin
              done_next   = 1'b1;
              status_next = STATUS_ERR;
              base_next   = '0;
            end else begin
              need_next  = CNT_W'(need_raw);
              state_next = S_SEARCH;
            end
          end
        end
      end

      // First-fit scan: one frame checked per cycle, next read in flight
      S_SEARCH: begin
        stay = 1'b1;
        if (rd_pend) begin
          if (rd_data.in_use) begin
            count_next = '0;
          end else begin
            if (count == '0) begin
              run_first_next = rd_idx;
            end
            count_next = count_plus;
            if (count_plus >= need) begin
              stay = 1'b0;
              if (need == '0) begin
                done_next   = 1'b1;
                status_next = STATUS_OK;
                base_next   = frame_to_base(found_first);
                state_next  = S_IDLE;
              end else begin
                run_first_next = found_first;
                mark_addr_next = found_first;
                count_next     = need;
                state_next     = S_MARK;
              end
            end
          end
          if (stay && rd_idx == LAST_FRAME) begin
            stay        = 1'b0;
            done_next   = 1'b1;
            status_next = STATUS_ERR;
            base_next   = '0;
            state_next  = S_IDLE;
          end
        end
        if (stay && 32'(scan) < FRAME_COUNT) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = scan[FRAME_W-1:0];
          rd_idx_next     = scan[FRAME_W-1:0];
          scan_next       = scan + CNT_W'(1);
          rd_pend_next    = 1'b1;
        end
      end

      // Claim the run one frame per cycle
      S_MARK: begin
        mem_req.wr_en             = 1'b1;
        mem_req.wr_addr           = mark_addr;
        mem_req.wr_data.in_use    = 1'b1;
        mem_req.wr_data.owner     = who;
        mem_req.wr_data.run_start = run_first;
        mark_addr_next            = mark_addr + FRAME_W'(1);
        count_next                = count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          done_next   = 1'b1;
          status_next = STATUS_OK;
          base_next   = frame_to_base(run_first);
          state_next  = S_IDLE;
        end
      end

      // Check the head frame, then release while the run start matches
      S_FREE: begin
        stay = 1'b1;
        if (rd_pend) begin
          if (first && (!rd_data.in_use || rd_data.owner != who)) begin
            stay        = 1'b0;
            done_next   = 1'b1;
            status_next = STATUS_ERR;
            base_next   = '0;
            state_next  = S_IDLE;
          end else if (rd_data.run_start == pf) begin
            mem_req.wr_en          = 1'b1;
            mem_req.wr_addr        = rd_idx;
            mem_req.wr_data        = rd_data;
            mem_req.wr_data.in_use = 1'b0;
            first_next             = 1'b0;
            if (rd_idx == LAST_FRAME) begin
              stay        = 1'b0;
              done_next   = 1'b1;
              status_next = STATUS_OK;
              base_next   = '0;
              state_next  = S_IDLE;
            end
          end else begin
            stay        = 1'b0;
            done_next   = 1'b1;
            status_next = STATUS_OK;
            base_next   = '0;
            state_next  = S_IDLE;
          end
        end
        if (stay && 32'(scan) < FRAME_COUNT) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = scan[FRAME_W-1:0];
          rd_idx_next     = scan[FRAME_W-1:0];
          scan_next       = scan + CNT_W'(1);
          rd_pend_next    = 1'b1;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // The release walk writes one frame while reading the next: never the same entry
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (mem_req.rd_en && mem_req.wr_en) |-> (mem_req.rd_addr != mem_req.wr_addr))
    else $error("frame table read and write hit the same entry");

  // The table is written only while clearing, marking or releasing
  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_req.wr_en |-> (state == S_CLEAR || state == S_MARK || state == S_FREE))
    else $error("frame table written outside clear, mark or free");

  // Every marking cycle claims a frame for the run's owner
  a_mark_claims: assert property (@(posedge clk) disable iff (rst)
    (state == S_MARK) |-> (mem_req.wr_en && mem_req.wr_data.in_use &&
                           mem_req.wr_data.owner == who))
    else $error("marking cycle without a claiming write");

  // An error result never carries an address
  a_err_base_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == STATUS_ERR) |-> (base_address == '0))
    else $error("error result with nonzero base address");
`endif

endmodule

// ===== sim/contiguous_page_frame_allocator_unit_tb.sv =====
// Self-checking testbench for the first-fit contiguous page frame allocator.
// Depends on cpfa_pkg and contiguous_page_frame_allocator_unit; a frame table
// model in this file predicts every answer.
`timescale 1ns / 1ps

module contiguous_page_frame_allocator_unit_tb;
  import cpfa_pkg::*;

  localparam int PAGE_BYTES   = 1 << FRAME_SHIFT;
  localparam int RANDOM_ITEMS = 555;
  // Slowest correct run: clearing pass plus, per request, a full scan, a full
  // mark pass and the longest sender gap; taken about three times over.
  localparam int LIMIT_CYCLES = 4000000;
  // Longest single request: take, full scan, full mark, answer.
  localparam int DRAIN_CYCLES = 2 * FRAME_COUNT + 64;

  typedef struct packed {
    logic              status;
    logic [BASE_W-1:0] base;
  } answer_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               opcode = OP_ALLOC;
  logic [LEN_W-1:0]   length_bytes = '0;
  logic [ADDR_W-1:0]  free_address = '0;
  logic [OWNER_W-1:0] requester_id = '0;
  logic               done;
  logic               status;
  logic [BASE_W-1:0]  base_address;

  // Frame table model
  logic               frame_used   [FRAME_COUNT];
  logic [OWNER_W-1:0] frame_holder [FRAME_COUNT];
  logic [FRAME_W-1:0] frame_head   [FRAME_COUNT];

  answer_t answers_due[$];

  int  fail_count     = 0;
  int  requests_sent  = 0;
  int  allocs_sent    = 0;
  int  frees_sent     = 0;
  int  answers_seen   = 0;
  int  error_answers  = 0;
  bit  idle_enabled   = 1'b1;

  contiguous_page_frame_allocator_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .length_bytes (length_bytes),
    .free_address (free_address),
    .requester_id (requester_id),
    .done         (done),
    .status       (status),
    .base_address (base_address)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // First frame of the first run of need free frames, or -1
  function automatic int first_fit(int need);
    int i;
    int run_len;
    int run_first;
    run_len   = 0;
    run_first = 0;
    if (need == 0) begin
      for (i = 0; i < FRAME_COUNT; i++)
        if (!frame_used[i]) return i;
      return -1;
    end
    if (need > FRAME_COUNT) return -1;
    for (i = 0; i < FRAME_COUNT; i++) begin
      if (frame_used[i]) begin
        run_len = 0;
      end else begin
        if (run_len == 0) run_first = i;
        run_len++;
        if (run_len >= need) return run_first;
      end
    end
    return -1;
  endfunction

  // Apply one request to the frame table model and return its answer
  function automatic answer_t allocator_answer(logic op, logic [LEN_W-1:0] len,
                                               logic [ADDR_W-1:0] addr,
                                               logic [OWNER_W-1:0] who);
    answer_t a;
    int need;
    int first;
    int pf;
    int i;
    a.status = STATUS_ERR;
    a.base   = '0;
    if (op == OP_ALLOC) begin
      need  = (int'(len) + PAGE_ROUND) >> FRAME_SHIFT;
      first = first_fit(need);
      if (first >= 0) begin
        for (i = first; i < first + need && i < FRAME_COUNT; i++) begin
          frame_used[i]   = 1'b1;
          frame_holder[i] = who;
          frame_head[i]   = FRAME_W'(first);
        end
        a.status = STATUS_OK;
        a.base   = BASE_W'(first << FRAME_SHIFT);
      end
    end else begin
      pf = int'(addr >> FRAME_SHIFT);
      if (pf < FRAME_COUNT && frame_used[pf] && frame_holder[pf] == who) begin
        // Release consecutive frames tagged with this run start
        for (i = pf; i < FRAME_COUNT && int'(frame_head[i]) == pf; i++)
          frame_used[i] = 1'b0;
        a.status = STATUS_OK;
      end
    end
    return a;
  endfunction

  function automatic int used_frames();
    int i;
    int n;
    n = 0;
    for (i = 0; i < FRAME_COUNT; i++)
      if (frame_used[i]) n++;
    return n;
  endfunction

  // Some frame in use, searched from a random point, or -1
  function automatic int pick_used_frame();
    int s;
    int k;
    int idx;
    s = $urandom_range(0, FRAME_COUNT - 1);
    for (k = 0; k < FRAME_COUNT; k++) begin
      idx = (s + k) % FRAME_COUNT;
      if (frame_used[idx]) return idx;
    end
    return -1;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (!idle_enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [LEN_W-1:0] bytes_for_pages(int pages);
    if (pages == 0) return '0;
    return LEN_W'((pages - 1) * PAGE_BYTES + $urandom_range(1, PAGE_BYTES));
  endfunction

  function automatic logic [ADDR_W-1:0] frame_addr(int frame, int offset);
    return ADDR_W'((frame << FRAME_SHIFT) + offset);
  endfunction

  // Drive one request, wait for its transfer, record its answer, then idle for a random gap
  task automatic send_request(input logic op, input logic [LEN_W-1:0] len,
                              input logic [ADDR_W-1:0] addr,
                              input logic [OWNER_W-1:0] who);
    int gap;
    start        <= 1'b1;
    opcode       <= op;
    length_bytes <= len;
    free_address <= addr;
    requester_id <= who;
    @(posedge clk);
    while (busy) @(posedge clk);
    answers_due.push_back(allocator_answer(op, len, addr, who));
    requests_sent++;
    if (op == OP_ALLOC) allocs_sent++;
    else frees_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_alloc(input logic [LEN_W-1:0] len, input logic [OWNER_W-1:0] who);
    send_request(OP_ALLOC, len, ADDR_W'($urandom()), who);
  endtask

  task automatic send_free(input logic [ADDR_W-1:0] addr, input logic [OWNER_W-1:0] who);
    send_request(OP_FREE, LEN_W'($urandom()), addr, who);
  endtask

  // Compare each result with the oldest answer due
  always @(posedge clk) begin
    if (!rst && done) begin
      answers_seen++;
      if (answers_due.size() == 0) begin
        $error("result with no request pending: status %0d base 0x%0h",
               status, base_address);
        fail_count++;
      end else begin
        answer_t want;
        want = answers_due.pop_front();
        if (status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, status);
          fail_count++;
        end
        if (base_address !== want.base) begin
          $error("base_address mismatch: expected 0x%0h, actual 0x%0h",
                 want.base, base_address);
          fail_count++;
        end
        if (want.status == STATUS_ERR) error_answers++;
      end
    end
  end

  // Zero length, single and double page allocations
  task automatic test_alloc_basic();
    send_alloc(24'd0, 8'h00);
    send_alloc(24'd1, 8'h5A);
    send_alloc(LEN_W'(PAGE_BYTES), 8'h5A);
    send_alloc(LEN_W'(PAGE_BYTES + 1), 8'hA5);
  endtask

  // Requests longer than the table
  task automatic test_oversize();
    send_alloc(24'hFFFFFF, 8'hFF);
    send_alloc(LEN_W'(FRAME_COUNT * PAGE_BYTES + 1), 8'h81);
  endtask

  // Foreign owner, middle of a run, beyond the table, unused frame
  task automatic test_free_errors();
    send_free(frame_addr(2, PAGE_BYTES - 1), 8'h5A);
    send_free(frame_addr(3, 0), 8'hA5);
    send_free(24'hFFFFFF, 8'hFF);
    send_free(ADDR_W'(FRAME_COUNT * PAGE_BYTES), 8'h00);
    send_free(frame_addr(500, 0), 8'h00);
  endtask

  // Release a run, free it twice, refill the hole, then empty the table
  task automatic test_free_release();
    send_free(frame_addr(2, 24'h123), 8'hA5);
    send_free(frame_addr(2, 0), 8'hA5);
    send_alloc(LEN_W'(2 * PAGE_BYTES), 8'h01);
    send_alloc(24'd0, 8'h7E);
    send_free(frame_addr(0, 0), 8'h5A);
    send_free(frame_addr(1, 0), 8'h5A);
    send_free(frame_addr(2, 0), 8'h01);
  endtask

  // Whole table as one run: nothing fits, not even a zero-length request; then release and refill it
  task automatic test_full_table();
    send_alloc(LEN_W'(FRAME_COUNT * PAGE_BYTES), 8'h33);
    send_alloc(24'd0, 8'h33);
    send_alloc(24'd1, 8'h44);
    send_free(frame_addr(FRAME_COUNT - 1, 0), 8'h33);
    send_free(frame_addr(0, 0), 8'h33);
    send_alloc(LEN_W'((FRAME_COUNT - 1) * PAGE_BYTES + 1), 8'hC3);
    send_free(frame_addr(0, 24'hFFF), 8'hC3);
  endtask

  // Mostly well-formed allocate and free traffic, with some broken frees
  task automatic test_random_mix();
    int n;
    int r;
    int frame;
    int hd;
    int pages;
    logic [LEN_W-1:0] len;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // Every so often run a stretch with no idling
      if (n % 50 == 0) idle_enabled = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (used_frames() > 3 * FRAME_COUNT / 4) r = $urandom_range(45, 99);
      frame = pick_used_frame();
      if (frame < 0 || r < 45) begin
        r = $urandom_range(0, 99);
        if (r < 15) pages = 0;
        else if (r < 80) pages = $urandom_range(1, 8);
        else if (r < 93) pages = $urandom_range(9, 64);
        else pages = $urandom_range(65, 400);
        len = bytes_for_pages(pages);
        if (r >= 98) len = LEN_W'($urandom());
        send_alloc(len, OWNER_W'($urandom()));
      end else if (r < 82) begin
        hd = int'(frame_head[frame]);
        send_free(frame_addr(hd, $urandom_range(0, PAGE_BYTES - 1)), frame_holder[hd]);
      end else if (r < 88) begin
        send_free(frame_addr(frame, $urandom_range(0, PAGE_BYTES - 1)),
                  frame_holder[frame] ^ OWNER_W'($urandom_range(1, 255)));
      end else if (r < 94) begin
        send_free(frame_addr(frame, $urandom_range(0, PAGE_BYTES - 1)),
                  frame_holder[frame]);
      end else begin
        send_free(ADDR_W'($urandom()), OWNER_W'($urandom()));
      end
    end
    idle_enabled = 1'b1;
  endtask

  // Give up on a hung run
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    for (int i = 0; i < FRAME_COUNT; i++) begin
      frame_used[i]   = 1'b0;
      frame_holder[i] = '0;
      frame_head[i]   = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_alloc_basic();
    test_oversize();
    test_free_errors();
    test_free_release();
    test_full_table();
    test_random_mix();

    // Drain: wait for every answer, then for the longest request
    start <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests (%0d allocate, %0d free); %0d results checked, %0d errors",
             requests_sent, allocs_sent, frees_sent, answers_seen, error_answers);
    $display("Covered zero-length, oversized, full-table, foreign, mid-run and out-of-range cases");
    if (fail_count == 0 && answers_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/cpfa_pkg.sv
hw/rtl/cpfa_frame_table.sv
hw/rtl/cpfa_ctrl.sv
hw/rtl/contiguous_page_frame_allocator_unit.sv
sim/contiguous_page_frame_allocator_unit_tb.sv
